FILE: hdl/nms_pkg.sv
// ----------------------------------------------------------------------------
// nms_pkg - shared types and constants for sorted-box suppression
// Box, probe and configuration types, register indexes and the edge-span
// helper used by the top level and by every cell of the kept-box chain.
// ----------------------------------------------------------------------------
package nms_pkg;

  localparam int MAX_KEPT_DEF = 64;    // kept-table depth (cells in the chain)
  localparam int MAX_INPUTS   = 1024;  // boxes per frame before position saturates

  localparam int COORD_W = 16;         // Q12.4 corner coordinate
  localparam int CLS_W   = 8;
  localparam int AREA_W  = 32;         // Q24.8 area
  localparam int THR_W   = 8;          // Q0.8 threshold
  localparam int POS_W   = 10;
  localparam int CFG_IDX_W = 2;

  localparam int POS_LIMIT = (MAX_INPUTS - 1 < 1023) ? (MAX_INPUTS - 1) : 1023;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(115);  // 0.45 in Q0.8, truncated

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IOU_THR   = 2'd0,
    REG_CLASS_AGN = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [CLS_W-1:0]   cls;
    logic [COORD_W-1:0] b;
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] t;
    logic [COORD_W-1:0] l;
  } box_t;

  typedef struct packed {
    box_t              box;
    logic [AREA_W-1:0] area;
  } probe_t;

  typedef struct packed {
    logic             agnostic;
    logic [THR_W-1:0] thr;
  } cfg_t;

  // Length of one side; an inverted side counts as zero.
  function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                              input logic [COORD_W-1:0] hi);
    logic [COORD_W-1:0] res;
    res = (hi > lo) ? (hi - lo) : '0;
    return res;
  endfunction

endpackage

FILE: hdl/nms_cell.sv
// ----------------------------------------------------------------------------
// nms_cell - one kept-box cell of the suppression chain
// Holds one stored box, compares the passing probe box against it in three
// registered steps and ORs its hit into the suppress flag moving down the row.
// ----------------------------------------------------------------------------
module nms_cell (
  input  logic            clk,
  input  nms_pkg::cfg_t   cfg,
  input  logic            ent_valid,
  input  logic            wr_en,
  input  nms_pkg::probe_t wr_data,
  input  nms_pkg::probe_t probe_i,
  output nms_pkg::probe_t probe_o,
  input  logic            acc_i,
  output logic            acc_o
);

  nms_pkg::probe_t ent_r;
  nms_pkg::probe_t probe_r;

  logic [nms_pkg::AREA_W-1:0]  a_inter_r;
  logic [nms_pkg::AREA_W:0]    a_sum_r;
  logic                        a_match_r;
  logic [nms_pkg::AREA_W-1:0]  b_inter_r;
  logic [nms_pkg::AREA_W:0]    b_uni_r;
  logic                        b_match_r;
  logic                        acc_r;

  logic [nms_pkg::COORD_W-1:0] ix_lo, ix_hi, iy_lo, iy_hi, iw, ih;
  logic [nms_pkg::AREA_W-1:0]  inter_a;
  logic                        match_a;
  logic [nms_pkg::AREA_W+8:0]  lhs_c, rhs_c;
  logic                        hit_c;

  // overlap rectangle of probe and stored box
  always_comb begin
    ix_lo = (probe_r.box.l > ent_r.box.l) ? probe_r.box.l : ent_r.box.l;
    ix_hi = (probe_r.box.r < ent_r.box.r) ? probe_r.box.r : ent_r.box.r;
    iy_lo = (probe_r.box.t > ent_r.box.t) ? probe_r.box.t : ent_r.box.t;
    iy_hi = (probe_r.box.b < ent_r.box.b) ? probe_r.box.b : ent_r.box.b;
    iw    = nms_pkg::span(ix_lo, ix_hi);
    ih    = nms_pkg::span(iy_lo, iy_hi);
    inter_a = {{nms_pkg::COORD_W{1'b0}}, iw} * {{nms_pkg::COORD_W{1'b0}}, ih};
    match_a = ent_valid && (cfg.agnostic || (ent_r.box.cls == probe_r.box.cls));
  end

  // inter*256 > thr*union
  always_comb begin
    lhs_c = {1'b0, b_inter_r, 8'b0};
    rhs_c = (nms_pkg::AREA_W+9)'(cfg.thr) * (nms_pkg::AREA_W+9)'(b_uni_r);
    hit_c = b_match_r && (lhs_c > rhs_c);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r <= wr_data;
    end
    probe_r   <= probe_i;
    a_inter_r <= inter_a;
    a_sum_r   <= {1'b0, probe_r.area} + {1'b0, ent_r.area};
    a_match_r <= match_a;
    b_inter_r <= a_inter_r;
    b_uni_r   <= a_sum_r - {1'b0, a_inter_r};
    b_match_r <= a_match_r;
    acc_r     <= acc_i | hit_c;
  end

  assign probe_o = probe_r;
  assign acc_o   = acc_r;

endmodule

FILE: hdl/nonmax_suppression_sorted_boxes.sv
// ----------------------------------------------------------------------------
// nonmax_suppression_sorted_boxes - greedy non-maximum suppression
// Score-sorted boxes are checked against the boxes kept so far in the frame
// by a row of MAX_KEPT cells; survivors are stored and reported as kept.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            contents
//  in_*     request    tvalid/tready        tdata: left, top, right, bottom
//                                           tuser: class_label, frame_start
//  out_*    result     tvalid/tready        tdata: input_position
//                                           tuser: keep, table_overflow
//  cfg_*    write      cfg_wr_en            index 0 iou_threshold,
//                                           index 1 class_agnostic
//
//  One request is in flight at a time. A result is registered once its
//  request has passed the RUN and DECIDE states, and the next request can be
//  taken in the cycle after the decision; RUN waits while the suppress flag
//  walks the cell row one cell per cycle behind three compare stages.
//  A pending result does not block the next request; only the final
//  decision waits for the output register to be free.
//  Reset empties the kept table and position counter and restores the
//  register defaults; the cell contents need no clearing.
//
module nonmax_suppression_sorted_boxes #(
  parameter int MAX_KEPT = nms_pkg::MAX_KEPT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [nms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nms_pkg::THR_W-1:0]    cfg_wdata,
  // request channel
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [63:0]                  in_tdata,   // left_edge, top_edge, right_edge, bottom_edge
  input  logic [8:0]                   in_tuser,   // class_label, frame_start
  // result channel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [15:0]                  out_tdata,  // input_position, zero fill
  output logic [1:0]                   out_tuser   // keep, table_overflow
);

  localparam int CNT_W = $clog2(MAX_KEPT + 1);
  localparam int CYC_W = $clog2(MAX_KEPT + 4);
  localparam int POS_W = nms_pkg::POS_W;

  // state machine
  nms_pkg::state_t state_r, state_nxt;
  logic [CYC_W-1:0] cyc_r, cyc_nxt;
  logic             in_fire;
  logic             decide_fire;

  // current request
  nms_pkg::box_t               box_r;
  logic [nms_pkg::AREA_W-1:0]  area_r;
  logic [POS_W-1:0]            pos_r;

  // frame bookkeeping
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [POS_W-1:0] box_cnt_r, box_cnt_nxt;
  logic [POS_W-1:0] pos_base;

  // configuration
  logic [nms_pkg::THR_W-1:0] thr_r;
  logic                      agn_r;
  nms_pkg::cfg_t             cell_cfg;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic             out_keep_r, out_ovf_r;
  logic [POS_W-1:0] out_pos_r;

  // cell row
  nms_pkg::probe_t       probe_c [0:MAX_KEPT];
  logic [MAX_KEPT:0]     acc_c;
  logic [MAX_KEPT-1:0]   ent_valid;
  logic [MAX_KEPT-1:0]   wr_sel;
  nms_pkg::probe_t       wr_data;

  logic keep_w, full_w, wr_go;

  assign in_fire  = in_tvalid && in_tready;
  assign keep_w   = !acc_c[MAX_KEPT];
  assign full_w   = (count_r == CNT_W'(MAX_KEPT));
  assign wr_go    = decide_fire && keep_w && !full_w;
  assign pos_base = in_tuser[8] ? '0 : box_cnt_r;

  // ---- control: state, cycle count, frame counters, output valid --------
  always_comb begin
    state_nxt   = state_r;
    cyc_nxt     = cyc_r;
    in_tready   = 1'b0;
    decide_fire = 1'b0;
    case (state_r)
      nms_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = nms_pkg::ST_RUN;
          cyc_nxt   = '0;
        end
      end
      nms_pkg::ST_RUN: begin
        // wait for the suppress flag to leave the last cell
        cyc_nxt = cyc_r + 1'b1;
        if (cyc_r == CYC_W'(MAX_KEPT + 3)) begin
          state_nxt = nms_pkg::ST_DECIDE;
        end
      end
      nms_pkg::ST_DECIDE: begin
        // hold the decision until the output register is free
        if (!out_valid_r || out_tready) begin
          decide_fire = 1'b1;
          state_nxt   = nms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nms_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt   = count_r;
    box_cnt_nxt = box_cnt_r;
    if (in_fire) begin
      // frame start empties the table before this box is checked
      if (in_tuser[8]) begin
        count_nxt = '0;
      end
      box_cnt_nxt = (pos_base < POS_W'(nms_pkg::POS_LIMIT)) ? pos_base + 1'b1 : pos_base;
    end
    if (wr_go) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (decide_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nms_pkg::ST_IDLE;
      cyc_r       <= '0;
      count_r     <= '0;
      box_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= nms_pkg::THR_RESET;
      agn_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cyc_r       <= cyc_nxt;
      count_r     <= count_nxt;
      box_cnt_r   <= box_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (nms_pkg::cfg_reg_t'(cfg_index))
          nms_pkg::REG_IOU_THR:   thr_r <= cfg_wdata;
          nms_pkg::REG_CLASS_AGN: agn_r <= cfg_wdata[0];
          default: ;  // drop writes beyond the register list
        endcase
      end
    end
  end

  // ---- payload: request box, its area and the result fields -------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      box_r <= '{cls: in_tuser[7:0], b: in_tdata[63:48], r: in_tdata[47:32],
                 t: in_tdata[31:16], l: in_tdata[15:0]};
      pos_r <= pos_base;
    end
    // area of the held request box, registered
    area_r <= {{nms_pkg::COORD_W{1'b0}}, nms_pkg::span(box_r.l, box_r.r)} *
              {{nms_pkg::COORD_W{1'b0}}, nms_pkg::span(box_r.t, box_r.b)};
    if (decide_fire) begin
      out_keep_r <= keep_w;
      out_ovf_r  <= keep_w && full_w;
      out_pos_r  <= pos_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16 - POS_W){1'b0}}, out_pos_r};
  assign out_tuser  = {out_ovf_r, out_keep_r};

  // ---- cell row ----------------------------------------------------------
  assign cell_cfg   = '{agnostic: agn_r, thr: thr_r};
  assign wr_data    = '{box: box_r, area: area_r};
  assign probe_c[0] = wr_data;
  assign acc_c[0]   = 1'b0;

  for (genvar gi = 0; gi < MAX_KEPT; gi++) begin : g_cell
    // an entry counts only below the fill level of this frame
    assign ent_valid[gi] = (count_r > CNT_W'(gi));
    assign wr_sel[gi]    = wr_go && (count_r == CNT_W'(gi));

    nms_cell u_cell (
      .clk       (clk),
      .cfg       (cell_cfg),
      .ent_valid (ent_valid[gi]),
      .wr_en     (wr_sel[gi]),
      .wr_data   (wr_data),
      .probe_i   (probe_c[gi]),
      .probe_o   (probe_c[gi+1]),
      .acc_i     (acc_c[gi]),
      .acc_o     (acc_c[gi+1])
    );
  end

  // ---- checks ------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_KEPT))
    else $error("kept count beyond table depth");

  a_ovf_needs_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_ovf_r || out_keep_r))
    else $error("overflow reported on a suppressed box");

  a_no_store_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_go |-> (count_r < CNT_W'(MAX_KEPT)))
    else $error("store into full table");

  a_decide_loads: assert property (@(posedge clk) disable iff (!rst_n)
    decide_fire |=> out_valid_r)
    else $error("decision did not load the result register");

  a_table_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nms_pkg::ST_RUN) |=> $stable(count_r))
    else $error("table fill changed while a box is in the row");

endmodule
